FILE: hw/rtl/scop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scop_pkg
// Shared types, fixed-point constants and the rounding multiply of the
// sine/cosine octant polynomial core.
// ----------------------------------------------------------------------------
package scop_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int OUT_FRAC_BITS_DEF = 16;
    localparam int Q_FRAC            = 30;
    localparam int Y_BITS            = 16;
    localparam int Q_BITS            = 32;

    typedef logic signed [Q_BITS-1:0] t_q;

    typedef enum logic [2:0] {
        OCT_0 = 3'd0,
        OCT_1 = 3'd1,
        OCT_2 = 3'd2,
        OCT_3 = 3'd3,
        OCT_4 = 3'd4,
        OCT_5 = 3'd5,
        OCT_6 = 3'd6,
        OCT_7 = 3'd7
    } t_octant;

    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    localparam t_q K_S0 = -32'sd209561;
    localparam t_q K_S1 = 32'sd8946640;
    localparam t_q K_S2 = -32'sd178956867;
    localparam t_q K_S3 = 32'sd1073741824;
    localparam t_q K_C0 = -32'sd1438890;
    localparam t_q K_C1 = 32'sd44706669;
    localparam t_q K_C2 = -32'sd536864416;
    localparam t_q K_C3 = 32'sd1073741609;
    localparam t_q K_RT = 32'sd759250113;

    // Q30 product, rounded to nearest with halves away from zero.
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [63:0] p;
        logic [63:0]        m;
        logic [Q_BITS-1:0]  r;
        p = 64'(a) * 64'(b);
        m = p[63] ? 64'(-p) : 64'(p);
        m = (m + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
        r = m[Q_BITS-1:0];
        return p[63] ? -$signed(r) : $signed(r);
    endfunction

endpackage

FILE: hw/rtl/scop_angle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scop_angle_if
// Input channel carrying one binary angle word per handshake.
// ----------------------------------------------------------------------------
interface scop_angle_if #(
    parameter int ANGLE_BITS = scop_pkg::ANGLE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);
endinterface

FILE: hw/rtl/scop_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scop_result_if
// Output channel carrying one sine/cosine word per handshake.
// ----------------------------------------------------------------------------
interface scop_result_if #(
    parameter int OUT_FRAC_BITS = scop_pkg::OUT_FRAC_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [OUT_FRAC_BITS+1:0] sin_out;
    logic signed [OUT_FRAC_BITS+1:0] cos_out;

    modport source (output valid, output sin_out, output cos_out, input ready);
    modport sink (input valid, input sin_out, input cos_out, output ready);
endinterface

FILE: hw/rtl/scop_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scop_reduce
// Stages one and two: octant split, residual scaled to radians, and its square.
// ----------------------------------------------------------------------------
module scop_reduce #(
    parameter int ANGLE_BITS = scop_pkg::ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output scop_pkg::t_octant     o_oct,
    output scop_pkg::t_q          o_y,
    output scop_pkg::t_q          o_z
);
    localparam int RES_BITS = ANGLE_BITS - 3;
    localparam int RSH      = ANGLE_BITS + 13;
    localparam int PW       = RES_BITS + 33;

    logic [PW-1:0]                  n_prod;
    logic [scop_pkg::Y_BITS-1:0]    r_y16;
    scop_pkg::t_octant              r_oct1;
    scop_pkg::t_octant              r_oct2;
    scop_pkg::t_q                   n_y;
    scop_pkg::t_q                   r_y;
    scop_pkg::t_q                   r_z;

    assign n_prod = PW'(i_angle[RES_BITS-1:0]) * PW'(scop_pkg::TWO_PI_Q29)
                  + (PW'(1) << (RSH - 1));
    assign n_y    = $signed({2'b00, r_y16, 14'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y16  <= n_prod[RSH+scop_pkg::Y_BITS-1:RSH];
            r_oct1 <= scop_pkg::t_octant'(i_angle[ANGLE_BITS-1 -: 3]);
            r_y    <= n_y;
            r_z    <= scop_pkg::qmul(n_y, n_y);
            r_oct2 <= r_oct1;
        end
    end

    assign o_oct = r_oct2;
    assign o_y   = r_y;
    assign o_z   = r_z;
endmodule

FILE: hw/rtl/scop_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scop_poly
// Stages three to six: Horner steps of the sine and cosine polynomials.
// ----------------------------------------------------------------------------
module scop_poly (
    input  logic              i_clk,
    input  logic              i_en,
    input  scop_pkg::t_octant i_oct,
    input  scop_pkg::t_q      i_y,
    input  scop_pkg::t_q      i_z,
    output scop_pkg::t_octant o_oct,
    output scop_pkg::t_q      o_sp,
    output scop_pkg::t_q      o_cp
);
    scop_pkg::t_octant r_oct [3:6];
    scop_pkg::t_q      r_y   [3:5];
    scop_pkg::t_q      r_z   [3:4];
    scop_pkg::t_q      r_sp  [3:6];
    scop_pkg::t_q      r_cp  [3:6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sp[3]  <= scop_pkg::qmul(scop_pkg::K_S0, i_z) + scop_pkg::K_S1;
            r_cp[3]  <= scop_pkg::qmul(scop_pkg::K_C0, i_z) + scop_pkg::K_C1;
            r_z[3]   <= i_z;
            r_y[3]   <= i_y;
            r_oct[3] <= i_oct;

            r_sp[4]  <= scop_pkg::qmul(r_z[3], r_sp[3]) + scop_pkg::K_S2;
            r_cp[4]  <= scop_pkg::qmul(r_z[3], r_cp[3]) + scop_pkg::K_C2;
            r_z[4]   <= r_z[3];
            r_y[4]   <= r_y[3];
            r_oct[4] <= r_oct[3];

            r_sp[5]  <= scop_pkg::qmul(r_z[4], r_sp[4]) + scop_pkg::K_S3;
            r_cp[5]  <= scop_pkg::qmul(r_z[4], r_cp[4]) + scop_pkg::K_C3;
            r_y[5]   <= r_y[4];
            r_oct[5] <= r_oct[4];

            r_sp[6]  <= scop_pkg::qmul(r_y[5], r_sp[5]);
            r_cp[6]  <= r_cp[5];
            r_oct[6] <= r_oct[5];
        end
    end

    assign o_oct = r_oct[6];
    assign o_sp  = r_sp[6];
    assign o_cp  = r_cp[6];
endmodule

FILE: hw/rtl/scop_octant.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scop_octant
// Stages seven to nine: 45 degree rotation, octant mapping, output rounding
// and saturation.
// ----------------------------------------------------------------------------
module scop_octant #(
    parameter int OUT_FRAC_BITS = scop_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  scop_pkg::t_octant               i_oct,
    input  scop_pkg::t_q                    i_sp,
    input  scop_pkg::t_q                    i_cp,
    output logic signed [OUT_FRAC_BITS+1:0] o_sin,
    output logic signed [OUT_FRAC_BITS+1:0] o_cos
);
    localparam int          OUT_W = OUT_FRAC_BITS + 2;
    localparam int          SH    = scop_pkg::Q_FRAC - OUT_FRAC_BITS;
    localparam logic [32:0] HALF  = (SH > 0) ? (33'd1 << ((SH > 0) ? SH - 1 : 0)) : 33'd0;
    localparam logic [32:0] LIM   = 33'd1 << OUT_FRAC_BITS;

    function automatic logic [OUT_W-1:0] to_out(input scop_pkg::t_q v);
        logic [32:0] mag;
        logic [32:0] neg_mag;
        mag = v[scop_pkg::Q_BITS-1] ? 33'(-v) : 33'(v);
        mag = (mag + HALF) >> SH;
        if (mag > LIM) begin
            mag = LIM;
        end
        neg_mag = ~mag + 33'd1;
        return v[scop_pkg::Q_BITS-1] ? neg_mag[OUT_W-1:0] : mag[OUT_W-1:0];
    endfunction

    scop_pkg::t_octant r_oct;
    scop_pkg::t_q      r_sp;
    scop_pkg::t_q      r_cp;
    scop_pkg::t_q      r_rs;
    scop_pkg::t_q      r_rc;
    scop_pkg::t_q      n_so;
    scop_pkg::t_q      n_co;
    scop_pkg::t_q      r_so;
    scop_pkg::t_q      r_co;
    logic [OUT_W-1:0]  r_sin;
    logic [OUT_W-1:0]  r_cos;

    always_comb begin
        unique case (r_oct)
            scop_pkg::OCT_0: begin
                n_so = r_sp;
                n_co = r_cp;
            end
            scop_pkg::OCT_1: begin
                n_so = r_rs + r_rc;
                n_co = r_rc - r_rs;
            end
            scop_pkg::OCT_2: begin
                n_so = r_cp;
                n_co = -r_sp;
            end
            scop_pkg::OCT_3: begin
                n_so = r_rc - r_rs;
                n_co = -r_rc - r_rs;
            end
            scop_pkg::OCT_4: begin
                n_so = -r_sp;
                n_co = -r_cp;
            end
            scop_pkg::OCT_5: begin
                n_so = -r_rs - r_rc;
                n_co = r_rs - r_rc;
            end
            scop_pkg::OCT_6: begin
                n_so = -r_cp;
                n_co = r_sp;
            end
            scop_pkg::OCT_7: begin
                n_so = r_rs - r_rc;
                n_co = r_rc + r_rs;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rs  <= scop_pkg::qmul(scop_pkg::K_RT, i_sp);
            r_rc  <= scop_pkg::qmul(scop_pkg::K_RT, i_cp);
            r_sp  <= i_sp;
            r_cp  <= i_cp;
            r_oct <= i_oct;
            r_so  <= n_so;
            r_co  <= n_co;
            r_sin <= to_out(r_so);
            r_cos <= to_out(r_co);
        end
    end

    assign o_sin = $signed(r_sin);
    assign o_cos = $signed(r_cos);
endmodule

FILE: hw/rtl/sin_cos_octant_polynomial_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sin_cos_octant_polynomial_core
// Sine and cosine of a binary angle by octant reduction and minimax polynomials.
// An accepted angle word passes through nine register stages to its result word.
// Throughput is one word per cycle; the nine stages advance together and hold
// while the output word waits to be taken.
// Reset clears the stage valid bits only; the data path is not reset.
// ----------------------------------------------------------------------------
module sin_cos_octant_polynomial_core #(
    parameter int ANGLE_BITS    = scop_pkg::ANGLE_BITS_DEF,
    parameter int OUT_FRAC_BITS = scop_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scop_angle_if.sink    i_angle,
    scop_result_if.source o_result
);
    localparam int STAGES = 9;

    logic              n_en;
    logic [STAGES-1:0] r_vld;
    scop_pkg::t_octant red_oct;
    scop_pkg::t_q      red_y;
    scop_pkg::t_q      red_z;
    scop_pkg::t_octant poly_oct;
    scop_pkg::t_q      poly_sp;
    scop_pkg::t_q      poly_cp;

    assign n_en          = ~r_vld[STAGES-1] | o_result.ready;
    assign i_angle.ready = n_en;
    assign o_result.valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_angle.valid};
        end
    end

    scop_reduce #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_angle (i_angle.angle),
        .o_oct   (red_oct),
        .o_y     (red_y),
        .o_z     (red_z)
    );

    scop_poly u_poly (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_oct (red_oct),
        .i_y   (red_y),
        .i_z   (red_z),
        .o_oct (poly_oct),
        .o_sp  (poly_sp),
        .o_cp  (poly_cp)
    );

    scop_octant #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_octant (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_oct (poly_oct),
        .i_sp  (poly_sp),
        .i_cp  (poly_cp),
        .o_sin (o_result.sin_out),
        .o_cos (o_result.cos_out)
    );
endmodule
